### design/bte_pkg.sv
package bte_pkg;

  // Table geometry: SEQ_SLOTS must be a power of two
  localparam int SEQ_SLOTS = 4096;
  localparam int SLOT_BITS = $clog2(SEQ_SLOTS);
  localparam int TIME_BITS = 48;
  localparam int TIME_KEEP = (TIME_BITS < 48) ? TIME_BITS : 48;
  localparam int SPAN_BITS = TIME_KEEP + 2;
  localparam int CNT_BITS = 13;
  localparam int DIV_CNT_BITS = $clog2(SPAN_BITS + 1);
  localparam int CFG_W = 24;
  localparam int OUT_W = 48;

  localparam logic [CFG_W-1:0] STALE_RESET = 24'd1000000;
  localparam logic [CNT_BITS-1:0] THR_RESET = 13'd10;
  localparam logic [CNT_BITS-1:0] THR_MIN = 13'd2;
  localparam logic [CNT_BITS-1:0] CNT_MAX = 13'h1FFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_OWN_CTL = 2'd0;
  localparam logic [1:0] CFG_OWN_BMP = 2'd1;
  localparam logic [1:0] CFG_STALE = 2'd2;
  localparam logic [1:0] CFG_THR = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_STORED = 2'd0;
  localparam logic [1:0] STAT_OWN_STALE = 2'd1;
  localparam logic [1:0] STAT_REAL_STALE = 2'd2;
  localparam logic [1:0] STAT_ADJUST = 2'd3;

  typedef struct packed {
    logic                 own_p;
    logic                 real_p;
    logic [TIME_KEEP-1:0] own_t;
    logic [TIME_KEEP-1:0] real_t;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_MOD,
    ST_SCAN,
    ST_DIFF,
    ST_SPAN,
    ST_DIVS,
    ST_DIVW,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [SPAN_BITS-1:0] dividend;
    logic [CNT_BITS-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [SPAN_BITS-1:0] quotient;
  } div_rsp_t;

endpackage

### design/bte_table.sv
module bte_table
  import bte_pkg::*;
(
  input  logic                 clk,
  input  logic [SLOT_BITS-1:0] rd_addr,
  output entry_t               rd_data,
  input  logic                 wr_en,
  input  logic [SLOT_BITS-1:0] wr_addr,
  input  entry_t               wr_data
);

  entry_t mem [SEQ_SLOTS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### design/bte_div.sv
module bte_div
  import bte_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [CNT_BITS:0]         rem_r, rem_nxt;
  logic [SPAN_BITS-1:0]      quo_r, quo_nxt;
  logic [CNT_BITS-1:0]       dvs_r;
  logic [DIV_CNT_BITS-1:0]   cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CNT_BITS:0]         shifted;

  // One quotient bit per cycle, restoring
  always_comb begin
    shifted = {rem_r[CNT_BITS-1:0], quo_r[SPAN_BITS-1]};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = '0;
      quo_nxt = req.dividend;
      cnt_nxt = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, dvs_r}) begin
        rem_nxt = shifted - {1'b0, dvs_r};
        quo_nxt = {quo_r[SPAN_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[SPAN_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_BITS'(SPAN_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
    if (req.start) begin
      dvs_r <= req.divisor;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;

endmodule

### design/beacon_timing_drift_estimator_top.sv
// Beacon timing drift estimator for one access point. Each beacon transaction
// passes through acceptance with the table read, a read-modify-write step and
// the result load; the table has one registered read port, so the slot read
// at acceptance is written back in the read-modify-write step. When the
// good-pair count reaches the threshold, an adjustment sweeps the whole table
// once (reading slots for the first and last pair and clearing them behind
// the read), then runs a bit-serial divide for the interval correction.
// After reset the table is cleared before the first beacon is taken;
// configuration writes are taken at any time. The result sits in an output
// register, so the next beacon may be accepted while a result waits to be
// taken.
module beacon_timing_drift_estimator_top
  import bte_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [11:0]             in_seq_number,
  input  logic [47:0]             in_timestamp_us,
  input  logic [7:0]              in_tim_control,
  input  logic [7:0]              in_tim_bitmap,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic signed [OUT_W-1:0] out_offset_us,
  output logic signed [OUT_W-1:0] out_interval_us,
  input  logic                    cfg_we,
  input  logic [1:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_wdata
);

  localparam logic signed [48:0] OFF_MAX = 49'sd140737488355327;
  localparam logic signed [48:0] OFF_MIN = -49'sd140737488355328;
  localparam logic [49:0] Q_MAX = 50'd140737488355327;
  localparam logic [49:0] Q_NEG_LIM = 50'd140737488355328;
  localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SEQ_SLOTS - 1);

  state_t state_r, state_nxt;

  // Configuration registers
  logic [7:0]          own_ctl_r, own_bmp_r;
  logic [CFG_W-1:0]    stale_r;
  logic [CNT_BITS-1:0] thr_r;

  // Held beacon
  logic [SLOT_BITS-1:0] it_slot_r;
  logic [TIME_KEEP-1:0] it_time_r;
  logic                 it_own_r;

  logic [CNT_BITS-1:0]  pair_cnt_r;

  // Sweep
  logic [SLOT_BITS:0]   scan_addr_r;
  logic                 scan_v_r;
  logic [SLOT_BITS-1:0] scan_idx_r;
  logic                 found_r;
  logic [TIME_KEEP-1:0] first_own_r, first_real_r, last_own_r, last_real_r;

  // Adjustment arithmetic
  logic signed [48:0]          off_r, d_real_r, d_own_r;
  logic signed [SPAN_BITS-1:0] spans_r;
  logic                        neg_r;

  // Pending result and output register
  logic [1:0]              res_status_r;
  logic signed [OUT_W-1:0] res_off_r, res_int_r;
  logic                    out_valid_r;
  logic [1:0]              out_status_r;
  logic signed [OUT_W-1:0] out_off_r, out_int_r;

  // Table port
  logic [SLOT_BITS-1:0] mem_ra, mem_wa;
  logic                 mem_we;
  entry_t               mem_rd, mem_wd;

  // Read-modify-write results
  entry_t               ent;
  logic                 paired, r_ge, stale_own, stale_real;
  logic [TIME_KEEP:0]   r_m_o, o_m_r;
  logic [CNT_BITS-1:0]  cnt_after, thr_eff;
  logic                 trigger, scan_end, out_free;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [49:0]             q_ext;
  logic signed [OUT_W-1:0] interval;

  bte_table u_table (
    .clk     (clk),
    .rd_addr (mem_ra),
    .rd_data (mem_rd),
    .wr_en   (mem_we),
    .wr_addr (mem_wa),
    .wr_data (mem_wd)
  );

  bte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Merge the beacon into its slot and judge the pair
  always_comb begin
    ent = mem_rd;
    if (it_own_r) begin
      ent.own_t = it_time_r;
      ent.own_p = 1'b1;
    end else begin
      ent.real_t = it_time_r;
      ent.real_p = 1'b1;
    end
    paired = ent.own_p & ent.real_p;
    r_m_o = {1'b0, ent.real_t} - {1'b0, ent.own_t};
    o_m_r = {1'b0, ent.own_t} - {1'b0, ent.real_t};
    r_ge = ~r_m_o[TIME_KEEP];
    stale_own = paired & r_ge & (r_m_o[TIME_KEEP-1:0] > TIME_KEEP'(stale_r));
    stale_real = paired & ~r_ge & (o_m_r[TIME_KEEP-1:0] > TIME_KEEP'(stale_r));
    cnt_after = pair_cnt_r;
    if (paired && (pair_cnt_r != CNT_MAX)) begin
      cnt_after = pair_cnt_r + 1'b1;
    end
    thr_eff = (thr_r < THR_MIN) ? THR_MIN : thr_r;
    trigger = (cnt_after >= thr_eff);
    scan_end = scan_v_r && (scan_idx_r == SLOT_LAST);
    out_free = ~out_valid_r | out_ready;
  end

  // Saturate the interval magnitude and restore its sign
  always_comb begin
    q_ext = 50'(div_rsp.quotient);
    if (neg_r) begin
      interval = (q_ext > Q_NEG_LIM) ? OFF_MIN[OUT_W-1:0] : OUT_W'(-q_ext);
    end else begin
      interval = (q_ext > Q_MAX) ? OFF_MAX[OUT_W-1:0] : OUT_W'(q_ext);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR: begin
        if (scan_addr_r[SLOT_BITS-1:0] == SLOT_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MOD;
      end
      ST_MOD: begin
        if (stale_own || stale_real || !trigger) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) state_nxt = ST_DIFF;
      end
      ST_DIFF: state_nxt = ST_SPAN;
      ST_SPAN: state_nxt = ST_DIVS;
      ST_DIVS: state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (div_rsp.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLR;
    endcase
  end

  // Table port and divider launch
  always_comb begin
    mem_ra = in_seq_number[SLOT_BITS-1:0];
    mem_we = 1'b0;
    mem_wa = it_slot_r;
    mem_wd = ent;
    div_req.start = 1'b0;
    div_req.dividend = spans_r[SPAN_BITS-1] ? SPAN_BITS'(-spans_r) : SPAN_BITS'(spans_r);
    div_req.divisor = pair_cnt_r - 1'b1;
    unique case (state_r)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = scan_addr_r[SLOT_BITS-1:0];
        mem_wd = '0;
      end
      ST_MOD: begin
        mem_we = 1'b1;
        if (stale_own) mem_wd.own_p = 1'b0;
        if (stale_real) mem_wd.real_p = 1'b0;
      end
      ST_SCAN: begin
        // Read ahead, clear the slot whose data just came back
        mem_ra = scan_addr_r[SLOT_BITS-1:0];
        mem_we = scan_v_r;
        mem_wa = scan_idx_r;
        mem_wd = mem_rd;
        mem_wd.own_p = 1'b0;
        mem_wd.real_p = 1'b0;
      end
      ST_DIVS: div_req.start = 1'b1;
      ST_IDLE, ST_DIFF, ST_SPAN, ST_DIVW, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      own_ctl_r <= '0;
      own_bmp_r <= '0;
      stale_r <= STALE_RESET;
      thr_r <= THR_RESET;
      pair_cnt_r <= '0;
      scan_addr_r <= '0;
      scan_v_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_OWN_CTL: own_ctl_r <= cfg_wdata[7:0];
          CFG_OWN_BMP: own_bmp_r <= cfg_wdata[7:0];
          CFG_STALE: stale_r <= cfg_wdata;
          CFG_THR: thr_r <= cfg_wdata[CNT_BITS-1:0];
          default: begin
          end
        endcase
      end
      // Flag the cycle whose read data belongs to the sweep
      scan_v_r <= (state_r == ST_SCAN) && !scan_addr_r[SLOT_BITS];
      unique case (state_r)
        ST_CLR: begin
          scan_addr_r <= (scan_addr_r[SLOT_BITS-1:0] == SLOT_LAST) ? '0 : scan_addr_r + 1'b1;
        end
        ST_MOD: begin
          if (!stale_own && !stale_real) pair_cnt_r <= cnt_after;
          scan_addr_r <= '0;
        end
        ST_SCAN: begin
          if (!scan_addr_r[SLOT_BITS]) begin
            scan_addr_r <= scan_addr_r + 1'b1;
          end
        end
        ST_DIVS: pair_cnt_r <= '0;
        ST_IDLE, ST_DIFF, ST_SPAN, ST_DIVW, ST_OUT: begin
        end
        default: begin
        end
      endcase
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end

    // Payload
    if (state_r == ST_IDLE) begin
      it_slot_r <= in_seq_number[SLOT_BITS-1:0];
      it_time_r <= in_timestamp_us[TIME_KEEP-1:0];
      it_own_r <= (in_tim_control == own_ctl_r) && (in_tim_bitmap == own_bmp_r);
    end
    if (state_r == ST_MOD) begin
      found_r <= 1'b0;
      first_own_r <= '0;
      first_real_r <= '0;
      last_own_r <= '0;
      last_real_r <= '0;
      res_off_r <= '0;
      res_int_r <= '0;
      if (stale_own) begin
        res_status_r <= STAT_OWN_STALE;
      end else if (stale_real) begin
        res_status_r <= STAT_REAL_STALE;
      end else begin
        res_status_r <= trigger ? STAT_ADJUST : STAT_STORED;
      end
    end
    if ((state_r == ST_SCAN) && scan_v_r && mem_rd.own_p && mem_rd.real_p) begin
      found_r <= 1'b1;
      if (!found_r) begin
        first_own_r <= mem_rd.own_t;
        first_real_r <= mem_rd.real_t;
      end
      last_own_r <= mem_rd.own_t;
      last_real_r <= mem_rd.real_t;
    end
    scan_idx_r <= scan_addr_r[SLOT_BITS-1:0];
    if (state_r == ST_DIFF) begin
      off_r <= $signed(49'(last_real_r)) - $signed(49'(last_own_r));
      d_real_r <= $signed(49'(last_real_r)) - $signed(49'(first_real_r));
      d_own_r <= $signed(49'(last_own_r)) - $signed(49'(first_own_r));
    end
    if (state_r == ST_SPAN) begin
      spans_r <= SPAN_BITS'(d_real_r) - SPAN_BITS'(d_own_r);
      if (off_r > OFF_MAX) begin
        res_off_r <= OFF_MAX[OUT_W-1:0];
      end else if (off_r < OFF_MIN) begin
        res_off_r <= OFF_MIN[OUT_W-1:0];
      end else begin
        res_off_r <= off_r[OUT_W-1:0];
      end
    end
    if (state_r == ST_DIVS) neg_r <= spans_r[SPAN_BITS-1];
    if ((state_r == ST_DIVW) && div_rsp.done) res_int_r <= interval;
    if ((state_r == ST_OUT) && out_free) begin
      out_status_r <= res_status_r;
      out_off_r <= res_off_r;
      out_int_r <= res_int_r;
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = out_status_r;
  assign out_offset_us = out_off_r;
  assign out_interval_us = out_int_r;

`ifndef ASSERT_OFF
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !mem_we)
    else $error("table written while idle");
  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD && state_nxt == ST_SCAN) |=> (pair_cnt_r >= THR_MIN))
    else $error("adjustment started with fewer than two pairs");
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIVW))
    else $error("divider finished outside its wait state");
  a_scan_data_state: assert property (@(posedge clk) disable iff (!rst_n)
    scan_v_r |-> (state_r == ST_SCAN))
    else $error("sweep data outside sweep");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

// Beacon drift estimator check: beacons go in through a queue-fed driver, a
// software copy of the slot table predicts each result, and a monitor
// compares every output transaction against the oldest prediction.
module testbench
  import bte_pkg::*;
;

  typedef struct packed {
    logic [11:0] seq;
    logic [47:0] ts;
    logic [7:0]  ctl;
    logic [7:0]  bmp;
  } beacon_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [47:0] offset;
    logic [47:0] interval;
  } verdict_t;

  localparam longint TS_MASK = (64'd1 << 48) - 1;
  localparam longint SAT_MAX = (64'd1 << 47) - 1;
  localparam longint SAT_MIN = -SAT_MAX - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid, in_ready, out_valid, out_ready;
  logic [1:0] out_status;
  logic signed [OUT_W-1:0] out_offset_us, out_interval_us;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_OWN_CTL;
  logic [CFG_W-1:0] cfg_wdata = '0;
  beacon_t cur = '0;

  // Mirror of the block's registers and slot table
  logic [7:0]  mdl_ctl, mdl_bmp;
  logic [23:0] mdl_stale;
  logic [12:0] mdl_thr, mdl_pairs;
  logic [47:0] mdl_own_t [SEQ_SLOTS];
  logic [47:0] mdl_real_t [SEQ_SLOTS];
  bit          mdl_own_p [SEQ_SLOTS];
  bit          mdl_real_p [SEQ_SLOTS];

  beacon_t  beacon_q[$];
  verdict_t verdict_q[$];
  int errors = 0;
  bit quiet = 0;
  int send_gap, recv_gap, hold_left;
  bit hold_kick = 0, hold_seen = 0;

  beacon_timing_drift_estimator_top u_top (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_seq_number(cur.seq), .in_timestamp_us(cur.ts),
    .in_tim_control(cur.ctl), .in_tim_bitmap(cur.bmp),
    .out_valid, .out_ready, .out_status, .out_offset_us, .out_interval_us,
    .cfg_we, .cfg_index, .cfg_wdata
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic longint sat48(longint v);
    if (v > SAT_MAX) return SAT_MAX;
    if (v < SAT_MIN) return SAT_MIN;
    return v;
  endfunction

  function automatic void clear_slots();
    for (int i = 0; i < SEQ_SLOTS; i++) begin
      mdl_own_p[i] = 0;
      mdl_real_p[i] = 0;
    end
    mdl_pairs = '0;
  endfunction

  // Work out the single result that one accepted beacon produces
  function automatic void predict_beacon(beacon_t b);
    int s;
    bit mine;
    longint r, o, fo, fr, lo, lr, spans;
    logic [12:0] thr;
    verdict_t v;
    s = int'(b.seq);
    mine = (b.ctl == mdl_ctl) && (b.bmp == mdl_bmp);
    v = '0;
    v.status = STAT_STORED;
    if (mine) begin
      mdl_own_t[s] = b.ts;
      mdl_own_p[s] = 1;
    end else begin
      mdl_real_t[s] = b.ts;
      mdl_real_p[s] = 1;
    end
    if (mdl_own_p[s] && mdl_real_p[s]) begin
      r = longint'(mdl_real_t[s]);
      o = longint'(mdl_own_t[s]);
      if (r >= o && r - o > longint'(mdl_stale)) begin
        mdl_own_p[s] = 0;
        v.status = STAT_OWN_STALE;
        verdict_q.push_back(v);
        return;
      end
      if (o > r && o - r > longint'(mdl_stale)) begin
        mdl_real_p[s] = 0;
        v.status = STAT_REAL_STALE;
        verdict_q.push_back(v);
        return;
      end
      if (mdl_pairs != CNT_MAX) mdl_pairs++;
    end
    thr = (mdl_thr < THR_MIN) ? THR_MIN : mdl_thr;
    if (mdl_pairs >= thr) begin
      fo = 0; fr = 0; lo = 0; lr = 0;
      for (int i = 0; i < SEQ_SLOTS; i++)
        if (mdl_own_p[i] && mdl_real_p[i]) begin
          fo = longint'(mdl_own_t[i]);
          fr = longint'(mdl_real_t[i]);
          break;
        end
      for (int i = SEQ_SLOTS - 1; i >= 0; i--)
        if (mdl_own_p[i] && mdl_real_p[i]) begin
          lo = longint'(mdl_own_t[i]);
          lr = longint'(mdl_real_t[i]);
          break;
        end
      spans = (lr - fr) - (lo - fo);
      v.status = STAT_ADJUST;
      v.offset = 48'(sat48(lr - lo));
      v.interval = 48'(sat48(spans / longint'(mdl_pairs - 1'b1)));
      clear_slots();
    end
    verdict_q.push_back(v);
  endfunction

  // Driver: hold a transaction until taken, then advance to the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) predict_beacon(cur);
      if (in_valid && !in_ready) begin
        // hold payload and valid
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (beacon_q.size() > 0) begin
        cur <= beacon_q.pop_front();
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 4) == 0) send_gap <= $urandom_range(1, 13);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted on its own
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_kick != hold_seen) begin
      hold_left <= 400;
      hold_seen <= hold_kick;
    end
  end

  // Monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    verdict_t exp_v;
    if (!rst_n) begin
      out_ready <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          report($sformatf("unexpected result status %0d", out_status));
        end else begin
          exp_v = verdict_q.pop_front();
          if (out_status !== exp_v.status)
            report($sformatf("status got %0d want %0d", out_status, exp_v.status));
          if (out_offset_us !== exp_v.offset)
            report($sformatf("offset got %h want %h", out_offset_us, exp_v.offset));
          if (out_interval_us !== exp_v.interval)
            report($sformatf("interval got %h want %h", out_interval_us, exp_v.interval));
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 13);
      end
    end
  end

  // Wait until every beacon is taken and every result has come back;
  // sample away from the rising edge so the driver's updates have settled
  task automatic drain();
    @(negedge clk);
    while (beacon_q.size() > 0 || in_valid || verdict_q.size() > 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_OWN_CTL: mdl_ctl = val[7:0];
      CFG_OWN_BMP: mdl_bmp = val[7:0];
      CFG_STALE:   mdl_stale = val;
      CFG_THR:     mdl_thr = val[12:0];
      default: begin
      end
    endcase
  endtask

  function automatic void push_beacon(int seq, longint ts, bit mine);
    beacon_t b;
    b.seq = 12'(seq);
    b.ts = 48'(ts & TS_MASK);
    b.ctl = mine ? mdl_ctl : 8'($urandom);
    b.bmp = mine ? mdl_bmp : 8'($urandom);
    // a random pair may still match ours; the predictor copes either way
    beacon_q.push_back(b);
  endfunction

  // Mostly own/real pairs within a narrow slot window, some stale, some noise
  task automatic random_phase(int n);
    int base, win, seq;
    longint now, jit;
    base = $urandom_range(0, SEQ_SLOTS - 1);
    win = $urandom_range(1, 16);
    now = {$urandom, $urandom} & TS_MASK;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) < 2) begin
        push_beacon($urandom_range(0, SEQ_SLOTS - 1), {$urandom, $urandom},
                    1'($urandom_range(0, 1)));
      end else begin
        seq = (base + $urandom_range(0, win - 1)) % SEQ_SLOTS;
        now += $urandom_range(50000, 150000);
        jit = $urandom_range(0, mdl_stale);
        if ($urandom_range(0, 9) == 0) jit = mdl_stale + $urandom_range(1, 5000);
        if ($urandom_range(0, 1)) jit = -jit;
        push_beacon(seq, now, 1);
        push_beacon(seq, now + jit, 0);
      end
    end
  endtask

  initial begin
    mdl_ctl = '0;
    mdl_bmp = '0;
    mdl_stale = STALE_RESET;
    mdl_thr = THR_RESET;
    for (int i = 0; i < SEQ_SLOTS; i++) begin
      mdl_own_t[i] = '0;
      mdl_real_t[i] = '0;
    end
    clear_slots();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, both sides, stale on either side, repeats
    push_beacon(0, 0, 1);
    push_beacon(0, 5, 0);
    push_beacon(4095, TS_MASK, 1);
    push_beacon(4095, TS_MASK - 3, 0);
    push_beacon(7, 100, 1);
    push_beacon(7, 2000100, 0);          // real far later: own side drops
    push_beacon(8, 3000000, 0);
    push_beacon(8, 100, 1);              // real far later again: own side drops
    push_beacon(9, 3000000, 1);
    push_beacon(9, 100, 0);              // own later than real: real drops
    push_beacon(0, 7, 0);                // repeated beacon counts the pair again
    push_beacon(2048, 48'hAAAA_AAAA_AAAA, 1);
    push_beacon(1365, 48'h5555_5555_5555, 0);
    drain();

    // Threshold below two acts as two: next clean beacon triggers the adjustment
    write_reg(CFG_THR, 24'd0);
    push_beacon(100, 1000, 0);
    drain();

    // Adjustment with no paired slot left: pair twice, then stale-clear it
    write_reg(CFG_OWN_CTL, 24'hFF);
    write_reg(CFG_OWN_BMP, 24'hFF);
    write_reg(CFG_STALE, 24'd0);
    write_reg(CFG_THR, 24'd10);
    push_beacon(5, 500, 1);
    push_beacon(5, 500, 0);
    push_beacon(5, 500, 0);
    push_beacon(5, 900, 1);
    drain();
    write_reg(CFG_THR, 24'd2);
    push_beacon(6, 1234, 0);
    drain();

    // Threshold of 4096 and largest stale limit: no adjustment fires
    write_reg(CFG_STALE, 24'hFFFFFF);
    write_reg(CFG_THR, 24'd4096);
    random_phase(20);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_OWN_CTL, 24'($urandom));
      write_reg(CFG_OWN_BMP, 24'($urandom));
      case ($urandom_range(0, 3))
        0: write_reg(CFG_STALE, 24'd0);
        1: write_reg(CFG_STALE, 24'hFFFFFF);
        default: write_reg(CFG_STALE, 24'($urandom_range(1000, 2000000)));
      endcase
      write_reg(CFG_THR, ($urandom_range(0, 4) == 0) ? 24'd2 : 24'($urandom_range(3, 24)));
      if (ph == 7) quiet = 1;
      random_phase(72);
      if (ph == 2) begin
        // stall the output long enough that the input backs up
        @(posedge clk);
        hold_kick <= ~hold_kick;
      end
      drain();
    end

    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #150_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
